// ----- rtl/hsr_pkg.sv -----
// Shared constants, codes and types of the history stack with search and replace.
`default_nettype none

package hsr_pkg;

  // Stack geometry.
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned ENTRY_WIDTH = 64;
  localparam int unsigned MAX_RESULTS = 64;

  // Entry count and walk step counter width, wide enough to hold DEPTH itself.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths on the stream ports.
  localparam int unsigned OP_W      = 3;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W = 2 * WORD_W;
  localparam int unsigned OUT_DATA_W = ((WORD_W + STATUS_W + 7) / 8) * 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_VIEW  = 3'd1;
  localparam logic [OP_W-1:0] OP_EDIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  // Shift control broadcast to every cell of the row.
  typedef struct packed {
    logic shift_en;  // move every entry one place this cycle
    logic shift_up;  // 1: toward the top (pop, walk), 0: toward the bottom (push)
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/hsr_cell.sv -----
// One storage cell of the stack row: holds one entry and takes a neighbor's entry on a shift.
`default_nettype none

module hsr_cell (
  input  wire logic                           clk_i,
  input  wire hsr_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [hsr_pkg::ENTRY_WIDTH-1:0] from_above_i,
  input  wire logic [hsr_pkg::ENTRY_WIDTH-1:0] from_below_i,
  output logic      [hsr_pkg::ENTRY_WIDTH-1:0] data_o
);

  logic [hsr_pkg::ENTRY_WIDTH-1:0] data_d, data_q;

  // Select the neighbor whose entry moves into this cell.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_en) begin
      data_d = ctrl_i.shift_up ? from_below_i : from_above_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/hsr_chain.sv -----
// Row of DEPTH cells; cell 0 holds the top of the stack.
`default_nettype none

module hsr_chain (
  input  wire logic                           clk_i,
  input  wire hsr_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [hsr_pkg::ENTRY_WIDTH-1:0] top_in_i,
  input  wire logic [hsr_pkg::ENTRY_WIDTH-1:0] bottom_in_i,
  output logic      [hsr_pkg::ENTRY_WIDTH-1:0] top_o
);

  logic [hsr_pkg::ENTRY_WIDTH-1:0] cell_data [hsr_pkg::DEPTH];

  // Each cell sees its upper and lower neighbor; the ends see the row inputs.
  for (genvar i = 0; i < hsr_pkg::DEPTH; i++) begin : g_cell
    logic [hsr_pkg::ENTRY_WIDTH-1:0] above, below;

    if (i == 0) begin : g_first
      assign above = top_in_i;
    end else begin : g_mid_above
      assign above = cell_data[i-1];
    end

    if (i == hsr_pkg::DEPTH - 1) begin : g_last
      assign below = bottom_in_i;
    end else begin : g_mid_below
      assign below = cell_data[i+1];
    end

    hsr_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .from_above_i (above),
      .from_below_i (below),
      .data_o       (cell_data[i])
    );
  end

  assign top_o = cell_data[0];

endmodule

`default_nettype wire

// ----- rtl/history_stack_with_replace_core.sv -----
// Top level of the history stack: request decode, walk sequencer and result register.
//
// Usage: requests arrive on the s_axis channel, one item per request, with the
// operation code on tuser and the search/push word and replacement word on tdata.
// Results leave on the m_axis channel; tlast marks the final result of a request.
// Entries live in a row of cells, top of stack in the first cell. Push and pop
// shift the whole row by one place; view and edit rotate the row once around,
// one place per cycle while a view is not waiting on the output, so every entry
// passes the top cell and the row ends where it started.
// Push, pop, peek, clear and unused codes load their result into the output register.
// View, on a non-empty stack, runs DEPTH rotation steps after acceptance that give
// one result per held entry; on an empty stack it gives a single empty result. Edit
// runs the same rotation plus a done state that registers its single result.
// A new request is taken only once the previous one has finished and its last
// result has left or is leaving the output register.
// Reset empties the stack (entry count 0) and drops any pending result.
// A stall on m_axis holds the result register; a view pauses its rotation until
// each result is taken, so nothing is lost or repeated.
`default_nettype none

module history_stack_with_replace_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request channel.
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: entry_value [63:0], new_value [127:64]
  input  wire logic [hsr_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: operation [2:0]
  input  wire logic [hsr_pkg::OP_W-1:0]        s_axis_tuser_i,
  // Result channel.
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tdata: value_out [63:0], status [65:64], zero fill [71:66]
  output logic      [hsr_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // tlast: last_of_run
  output logic                                 m_axis_tlast_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int unsigned EW = hsr_pkg::ENTRY_WIDTH;
  localparam int unsigned CW = hsr_pkg::CNT_W;

  logic [1:0]                      state_d, state_q;
  logic [CW-1:0]                   count_d, count_q;
  logic [CW-1:0]                   step_d, step_q;
  logic                            found_d, found_q;
  logic [hsr_pkg::OP_W-1:0]        op_d, op_q;
  logic [EW-1:0]                   key_d, key_q;
  logic [EW-1:0]                   repl_d, repl_q;

  logic                            m_valid_d, m_valid_q;
  logic [hsr_pkg::WORD_W-1:0]      m_value_d, m_value_q;
  logic [hsr_pkg::STATUS_W-1:0]    m_status_d, m_status_q;
  logic                            m_last_d, m_last_q;

  hsr_pkg::cell_ctrl_t             cell_ctrl;
  logic [EW-1:0]                   top_word;
  logic [EW-1:0]                   bottom_in;
  logic [EW-1:0]                   in_key;
  logic [EW-1:0]                   in_repl;
  logic [hsr_pkg::OP_W-1:0]        in_op;

  logic                            out_free;
  logic                            in_accept;
  logic [CW-1:0]                   shown;
  logic                            step_end;
  logic                            edit_match;
  logic                            emit;
  logic [hsr_pkg::WORD_W-1:0]      emit_value;
  logic [hsr_pkg::STATUS_W-1:0]    emit_status;
  logic                            emit_last;

  assign in_op   = s_axis_tuser_i;
  assign in_key  = s_axis_tdata_i[EW-1:0];
  assign in_repl = s_axis_tdata_i[hsr_pkg::WORD_W +: EW];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Number of view results and walk bookkeeping.
  assign shown    = (count_q < CW'(hsr_pkg::MAX_RESULTS)) ? count_q
                                                           : CW'(hsr_pkg::MAX_RESULTS);
  assign step_end = (step_q == CW'(hsr_pkg::DEPTH - 1));
  assign edit_match = (state_q == S_WALK) && (op_q == hsr_pkg::OP_EDIT) && !found_q &&
                      (step_q < count_q) && (top_word == key_q);

  // During a walk the top entry wraps to the bottom; an edit match wraps the replacement.
  assign bottom_in = edit_match ? repl_q : top_word;

  // Request decode and walk sequencing.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    found_d     = found_q;
    op_d        = op_q;
    key_d       = key_q;
    repl_d      = repl_q;
    cell_ctrl   = '0;
    emit        = 1'b0;
    emit_value  = '0;
    emit_status = hsr_pkg::STAT_OK;
    emit_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            hsr_pkg::OP_PUSH: begin
              emit = 1'b1;
              if (count_q == CW'(hsr_pkg::DEPTH)) begin
                emit_status = hsr_pkg::STAT_FULL;
              end else begin
                cell_ctrl.shift_en = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            hsr_pkg::OP_VIEW: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = hsr_pkg::STAT_EMPTY;
              end else begin
                state_d = S_WALK;
                step_d  = '0;
                op_d    = in_op;
              end
            end
            hsr_pkg::OP_EDIT: begin
              state_d = S_WALK;
              step_d  = '0;
              found_d = 1'b0;
              op_d    = in_op;
              key_d   = in_key;
              repl_d  = in_repl;
            end
            hsr_pkg::OP_POP: begin
              emit = 1'b1;
              if (count_q == '0) begin
                emit_status = hsr_pkg::STAT_EMPTY;
              end else begin
                cell_ctrl.shift_en = 1'b1;
                cell_ctrl.shift_up = 1'b1;
                count_d = count_q - CW'(1);
              end
            end
            hsr_pkg::OP_PEEK: begin
              emit = 1'b1;
              if (count_q == '0) begin
                emit_status = hsr_pkg::STAT_EMPTY;
              end else begin
                emit_value = hsr_pkg::WORD_W'(top_word);
              end
            end
            hsr_pkg::OP_CLEAR: begin
              emit    = 1'b1;
              count_d = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        // A view result waits for room in the output register before the row moves.
        if ((op_q == hsr_pkg::OP_VIEW) && (step_q < shown)) begin
          if (out_free) begin
            emit               = 1'b1;
            emit_value         = hsr_pkg::WORD_W'(top_word);
            emit_last          = (step_q + CW'(1) == shown);
            cell_ctrl.shift_en = 1'b1;
            cell_ctrl.shift_up = 1'b1;
          end
        end else begin
          cell_ctrl.shift_en = 1'b1;
          cell_ctrl.shift_up = 1'b1;
        end

        if (edit_match) begin
          found_d = 1'b1;
        end

        if (cell_ctrl.shift_en) begin
          step_d = step_q + CW'(1);
          if (step_end) begin
            state_d = (op_q == hsr_pkg::OP_EDIT) ? S_DONE : S_IDLE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = found_q ? hsr_pkg::STAT_OK : hsr_pkg::STAT_NOTFOUND;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loads on a new result, clears once taken.
  always_comb begin
    m_valid_d  = m_valid_q;
    m_value_d  = m_value_q;
    m_status_d = m_status_q;
    m_last_d   = m_last_q;
    if (emit) begin
      m_valid_d  = 1'b1;
      m_value_d  = emit_value;
      m_status_d = emit_status;
      m_last_d   = emit_last;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      step_q    <= '0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      step_q    <= step_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    repl_q     <= repl_d;
    m_value_q  <= m_value_d;
    m_status_q <= m_status_d;
    m_last_q   <= m_last_d;
  end

  // Entry storage.
  hsr_chain u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (cell_ctrl),
    .top_in_i    (in_key),
    .bottom_in_i (bottom_in),
    .top_o       (top_word)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(hsr_pkg::OUT_DATA_W - hsr_pkg::WORD_W - hsr_pkg::STATUS_W)'(0),
                            m_status_q, m_value_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire
